// ----- sv/timed_duplicate_filter_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the timed duplicate filter
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef TIMED_DUPLICATE_FILTER_MACROS_SVH
`define TIMED_DUPLICATE_FILTER_MACROS_SVH

// Same-cycle implication.
`define TDF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TDF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/tdf_pkg.sv -----
// ----------------------------------------------------------------------------
// Timed duplicate filter package
// Shared constants, payload types and the CRC byte step.
// ----------------------------------------------------------------------------
`default_nettype none

package tdf_pkg;

  localparam int unsigned BUCKET_BITS_DEF = 8;
  localparam int unsigned WAYS_DEF        = 4;
  localparam int unsigned KEY_BITS_DEF    = 64;
  localparam int unsigned TIME_BITS_DEF   = 32;

  localparam logic [31:0] TTL_RESET = 32'd1250;
  localparam logic [31:0] GOLDEN_32 = 32'h61C8_8647;
  localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;

  typedef struct packed {
    logic [63:0] source_key;
    logic [31:0] sequence_number;
    logic [31:0] now_ticks;
  } tdf_in_t;

  typedef struct packed {
    logic is_duplicate;
    logic was_tracked;
  } tdf_out_t;

  // back end status seen by the top level
  typedef struct packed {
    logic clearing;
    logic busy;
  } tdf_status_t;

  // reflected CRC-32, one byte, lsb first
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
    logic [31:0] c;
    c = crc ^ {24'd0, data};
    for (int b = 0; b < 8; b++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- sv/timed_duplicate_filter.sv -----
// ----------------------------------------------------------------------------
// Timed duplicate filter
// Hashed duplicate detection table whose entries expire after ttl_ticks.
// ----------------------------------------------------------------------------
// Each request carries a source key, a sequence number and the current tick
// count and yields exactly one response: is_duplicate when a live entry with
// the same key and sequence sits in the hashed bucket, was_tracked when the
// request was stored in a free way, neither when the bucket is full. Entries
// older than ttl_ticks are dropped on each visit to their bucket. The front end
// takes a request, runs the serial CRC-32 over each key byte in turn, then does
// the hash multiply and push, which waits while the queue is full. The back end
// reads the bucket row into a register, then compares and writes it back before
// it takes the next request, so the byte-serial CRC sets the sustained rate. A
// two-entry queue separates the halves, and a result register lets a new request
// enter while a response still waits. After reset the table is cleared one bucket
// row per cycle, all 2^BUCKET_BITS rows (256 at defaults), with in_ready_o low. The
// user must write ttl_ticks via cfg_we_i/cfg_wdata_i only while idle (unenforced).
`default_nettype none

`include "timed_duplicate_filter_macros.svh"

module timed_duplicate_filter
  import tdf_pkg::*;
#(
  parameter int unsigned BUCKET_BITS = BUCKET_BITS_DEF,
  parameter int unsigned WAYS        = WAYS_DEF,
  parameter int unsigned KEY_BITS    = KEY_BITS_DEF,
  parameter int unsigned TIME_BITS   = TIME_BITS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output      logic        in_ready_o,
  input  wire tdf_in_t     in_data_i,
  output      logic        out_valid_o,
  input  wire logic        out_ready_i,
  output      tdf_out_t    out_data_o
);

  localparam int unsigned ItemW = BUCKET_BITS + KEY_BITS + 32 + TIME_BITS;

  // time-to-live register
  logic [31:0] ttl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ttl_q <= TTL_RESET;
    end else if (cfg_we_i) begin
      ttl_q <= cfg_wdata_i;
    end
  end

  // front -> queue -> back
  logic             push_valid, push_ready;
  logic [ItemW-1:0] push_data;
  logic             pop_valid, pop_ready;
  logic [ItemW-1:0] pop_data;
  tdf_status_t      status;

  // no requests while the table clear runs
  tdf_front #(
    .BUCKET_BITS (BUCKET_BITS),
    .KEY_BITS    (KEY_BITS),
    .TIME_BITS   (TIME_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (!status.clearing),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  tdf_queue #(
    .WIDTH (ItemW)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  tdf_back #(
    .BUCKET_BITS (BUCKET_BITS),
    .WAYS        (WAYS),
    .KEY_BITS    (KEY_BITS),
    .TIME_BITS   (TIME_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ttl_i       (ttl_q),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .status_o    (status)
  );

  // nothing enters or leaves while the table is being cleared
  `TDF_ASSERT_NOW(a_clear_quiet, status.clearing, !in_ready_o && !out_valid_o, "activity during clear")
  // a response is never both duplicate and newly tracked
  `TDF_ASSERT_NOW(a_flags_exclusive, out_valid_o, !(out_data_o.is_duplicate && out_data_o.was_tracked), "both flags set")
  // the evaluate cycle always lands a response in the output register
  `TDF_ASSERT_NEXT(a_eval_delivers, status.busy, out_valid_o, "evaluate without response")

endmodule

`default_nettype wire

// ----- sv/tdf_front.sv -----
// ----------------------------------------------------------------------------
// Timed duplicate filter front end
// Takes a request, runs the key CRC a byte per cycle, hashes to a bucket.
// ----------------------------------------------------------------------------
`default_nettype none

module tdf_front
  import tdf_pkg::*;
#(
  parameter int unsigned BUCKET_BITS = BUCKET_BITS_DEF,
  parameter int unsigned KEY_BITS    = KEY_BITS_DEF,
  parameter int unsigned TIME_BITS   = TIME_BITS_DEF,
  localparam int unsigned ItemW      = BUCKET_BITS + KEY_BITS + 32 + TIME_BITS
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire logic             in_valid_i,
  output      logic             in_ready_o,
  input  wire tdf_in_t          in_data_i,
  output      logic             push_valid_o,
  input  wire logic             push_ready_i,
  output      logic [ItemW-1:0] push_data_o
);

  localparam int unsigned KeyBytes = (KEY_BITS + 7) / 8;
  localparam int unsigned KeyW     = KeyBytes * 8;
  localparam int unsigned CntW     = $clog2(KeyBytes) + 1;

  typedef struct packed {
    logic [BUCKET_BITS-1:0] bucket;
    logic [KEY_BITS-1:0]    key;
    logic [31:0]            seq;
    logic [TIME_BITS-1:0]   now;
  } item_t;

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_CRC  = 3'b010,
    F_HASH = 3'b100
  } front_state_e;

  front_state_e         state_q, state_d;
  logic [KEY_BITS-1:0]  key_q, key_d;
  logic [KeyW-1:0]      shift_q, shift_d;
  logic [31:0]          seq_q, seq_d;
  logic [TIME_BITS-1:0] now_q, now_d;
  logic [31:0]          crc_q, crc_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [31:0]          hash;
  item_t                item;

  assign in_ready_o   = (state_q == F_IDLE) && en_i;
  assign push_valid_o = (state_q == F_HASH);

  // product lands in the queue register
  assign hash = (crc_q ^ seq_q) * GOLDEN_32;

  assign item.bucket = hash[31 -: BUCKET_BITS];
  assign item.key    = key_q;
  assign item.seq    = seq_q;
  assign item.now    = now_q;
  assign push_data_o = item;

  always_comb begin
    state_d = state_q;
    key_d   = key_q;
    shift_d = shift_q;
    seq_d   = seq_q;
    now_d   = now_q;
    crc_d   = crc_q;
    cnt_d   = cnt_q;
    case (state_q)
      F_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          key_d   = in_data_i.source_key[KEY_BITS-1:0];
          shift_d = KeyW'(in_data_i.source_key[KEY_BITS-1:0]);
          seq_d   = in_data_i.sequence_number;
          now_d   = TIME_BITS'(in_data_i.now_ticks);
          crc_d   = '0;
          cnt_d   = '0;
          state_d = F_CRC;
        end
      end
      F_CRC: begin
        crc_d   = crc_byte(crc_q, shift_q[7:0]);
        shift_d = shift_q >> 8;
        cnt_d   = cnt_q + 1'b1;
        if (cnt_q == CntW'(KeyBytes - 1)) begin
          state_d = F_HASH;
        end
      end
      F_HASH: begin
        if (push_ready_i) begin
          state_d = F_IDLE;
        end
      end
      default: begin
        state_d = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    shift_q <= shift_d;
    seq_q   <= seq_d;
    now_q   <= now_d;
    crc_q   <= crc_d;
    cnt_q   <= cnt_d;
  end

endmodule

`default_nettype wire

// ----- sv/tdf_queue.sv -----
// ----------------------------------------------------------------------------
// Timed duplicate filter queue
// Two-entry FIFO between front end and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module tdf_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_valid_i,
  output      logic             push_ready_o,
  input  wire logic [WIDTH-1:0] push_data_i,
  output      logic             pop_valid_o,
  input  wire logic             pop_ready_i,
  output      logic [WIDTH-1:0] pop_data_o
);

  localparam int unsigned Depth = 2;

  logic [WIDTH-1:0] slot_q [Depth];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       cnt_q;
  logic             push, pop;

  assign push_ready_o = (cnt_q != 2'(Depth));
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_data_o   = slot_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// ----- sv/tdf_back.sv -----
// ----------------------------------------------------------------------------
// Timed duplicate filter back end
// Reads a bucket row, expires and matches its ways, writes the row back.
// ----------------------------------------------------------------------------
`default_nettype none

module tdf_back
  import tdf_pkg::*;
#(
  parameter int unsigned BUCKET_BITS = BUCKET_BITS_DEF,
  parameter int unsigned WAYS        = WAYS_DEF,
  parameter int unsigned KEY_BITS    = KEY_BITS_DEF,
  parameter int unsigned TIME_BITS   = TIME_BITS_DEF,
  localparam int unsigned ItemW      = BUCKET_BITS + KEY_BITS + 32 + TIME_BITS
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [31:0]      ttl_i,
  input  wire logic             pop_valid_i,
  output      logic             pop_ready_o,
  input  wire logic [ItemW-1:0] pop_data_i,
  output      logic             out_valid_o,
  input  wire logic             out_ready_i,
  output      tdf_out_t         out_data_o,
  output      tdf_status_t      status_o
);

  localparam int unsigned Buckets = 1 << BUCKET_BITS;

  typedef struct packed {
    logic [BUCKET_BITS-1:0] bucket;
    logic [KEY_BITS-1:0]    key;
    logic [31:0]            seq;
    logic [TIME_BITS-1:0]   now;
  } item_t;

  typedef struct packed {
    logic                 vld;
    logic [KEY_BITS-1:0]  key;
    logic [31:0]          seq;
    logic [TIME_BITS-1:0] stamp;
  } way_t;

  typedef way_t [WAYS-1:0] row_t;

  typedef enum logic [2:0] {
    B_CLEAR = 3'b001,
    B_IDLE  = 3'b010,
    B_EVAL  = 3'b100
  } back_state_e;

  row_t                   mem [Buckets];
  row_t                   rd_row_q;
  item_t                  cur_q, pop_item;
  back_state_e            state_q, state_d;
  logic [BUCKET_BITS-1:0] clr_q, clr_d;
  logic                   out_valid_q, out_valid_d;
  tdf_out_t               out_q, out_d;

  logic                   pop;
  logic                   wr_en;
  logic [BUCKET_BITS-1:0] wr_addr;
  row_t                   wr_row, new_row;
  logic [TIME_BITS-1:0]   ttl_t;
  logic [WAYS-1:0][TIME_BITS-1:0] diff;
  logic [WAYS-1:0]        live, match;
  logic                   found, taken;

  assign pop_item    = pop_data_i;
  assign pop_ready_o = (state_q == B_IDLE) && (!out_valid_q || out_ready_i);
  assign pop         = pop_valid_i && pop_ready_o;
  assign ttl_t       = TIME_BITS'(ttl_i);

  // expiry: top bit of stamp + ttl - now
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      diff[w]  = rd_row_q[w].stamp + ttl_t - cur_q.now;
      live[w]  = rd_row_q[w].vld && !diff[w][TIME_BITS-1];
      match[w] = live[w] && (rd_row_q[w].key == cur_q.key) && (rd_row_q[w].seq == cur_q.seq);
    end
  end

  assign found = |match;

  // expired ways drop out; with no match, the lowest free way takes a new entry
  always_comb begin
    taken = 1'b0;
    for (int w = 0; w < WAYS; w++) begin
      new_row[w]     = rd_row_q[w];
      new_row[w].vld = live[w];
      if (!found && !live[w] && !taken) begin
        new_row[w].vld   = 1'b1;
        new_row[w].key   = cur_q.key;
        new_row[w].seq   = cur_q.seq;
        new_row[w].stamp = cur_q.now;
        taken            = 1'b1;
      end
    end
  end

  assign wr_en   = (state_q == B_CLEAR) || (state_q == B_EVAL);
  assign wr_addr = (state_q == B_CLEAR) ? clr_q : cur_q.bucket;
  assign wr_row  = (state_q == B_CLEAR) ? row_t'('0) : new_row;

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    case (state_q)
      B_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == '1) begin
          state_d = B_IDLE;
        end
      end
      B_IDLE: begin
        if (pop) begin
          state_d = B_EVAL;
        end
      end
      B_EVAL: begin
        out_valid_d        = 1'b1;
        out_d.is_duplicate = found;
        out_d.was_tracked  = taken;
        state_d            = B_IDLE;
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (pop) begin
      cur_q <= pop_item;
    end
  end

  // bucket table: one row write, one registered row read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
    if (pop) begin
      rd_row_q <= mem[pop_item.bucket];
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_q;
  assign status_o.clearing = (state_q == B_CLEAR);
  assign status_o.busy     = (state_q == B_EVAL);

endmodule

`default_nettype wire

// ----- tb/sv/tb_timed_duplicate_filter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timed duplicate filter testbench
// A table of directed requests, then randomized traffic under several ttl
// settings. Responses are checked against the bench model or typed verdicts.
// ----------------------------------------------------------------------------

module tb_timed_duplicate_filter;
  import tdf_pkg::*;

  localparam int unsigned BKT_BITS  = BUCKET_BITS_DEF;
  localparam int unsigned BUCKETS   = 1 << BKT_BITS;
  localparam int unsigned WAYS      = WAYS_DEF;
  localparam int unsigned KEY_BYTES = (KEY_BITS_DEF + 7) / 8;
  localparam logic [63:0] KEY_MASK  = ~64'd0 >> (64 - KEY_BITS_DEF);

  localparam int PROBE_ROWS     = 16;
  localparam int PHASES         = 5;
  localparam int PHASE_REQUESTS = 300;
  localparam int RECENT_DEPTH   = 32;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 20;
  localparam int CYCLE_LIMIT    = 400_000;

  localparam tdf_out_t NEW_ENTRY = '{is_duplicate: 1'b0, was_tracked: 1'b1};
  localparam tdf_out_t DUPLICATE = '{is_duplicate: 1'b1, was_tracked: 1'b0};
  localparam tdf_out_t UNTRACKED = '{is_duplicate: 1'b0, was_tracked: 1'b0};

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [31:0] cfg_wdata_i = '0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  tdf_in_t     in_data_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  tdf_out_t    out_data_o;

  timed_duplicate_filter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Model of the table: ttl, per-slot valid, key, sequence and time stamp
  // --------------------------------------------------------------------------
  logic [31:0] ttl_model = TTL_RESET;
  bit          slot_live  [BUCKETS*WAYS];
  logic [63:0] slot_key   [BUCKETS*WAYS];
  logic [31:0] slot_seq   [BUCKETS*WAYS];
  logic [31:0] slot_stamp [BUCKETS*WAYS];

  typedef struct {
    tdf_in_t  req;
    tdf_out_t verdict;
  } awaited_t;

  awaited_t    awaited_q [$];   // responses still owed by the block, oldest first
  tdf_in_t     recent_q  [$];   // latest accepted requests, replayed for duplicates
  int          mismatches   = 0;
  int          send_quiet   = 0;
  int          recv_quiet   = 0;
  bit          hold_outputs = 1'b0;
  int unsigned cycle_count  = 0;
  logic [31:0] golden_inv;      // inverse of the hash multiplier mod 2^32

  // CRC-32, reflected, zero init, no final xor, low byte first
  function automatic logic [31:0] key_checksum(input logic [63:0] key);
    logic [31:0] crc;
    int          i;
    int          b;
    crc = '0;
    for (i = 0; i < KEY_BYTES; i++) begin
      crc = crc ^ {24'd0, key[8*i +: 8]};
      for (b = 0; b < 8; b++) begin
        crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
      end
    end
    return crc;
  endfunction

  function automatic int unsigned hash_bucket(input logic [63:0] key, input logic [31:0] seq);
    logic [31:0] h;
    h = (key_checksum(key) ^ seq) * GOLDEN_32;
    return h >> (32 - BKT_BITS);
  endfunction

  // stale once stamp + ttl - now goes negative, modulo 2^32
  function automatic bit entry_stale(input logic [31:0] stamp, input logic [31:0] now);
    logic [31:0] d;
    d = stamp + ttl_model - now;
    return d[31];
  endfunction

  function automatic tdf_out_t predict_verdict(input tdf_in_t req);
    logic [63:0] key;
    int unsigned base;
    int unsigned e;
    int          w;
    int          free_way;
    bit          hit;
    key      = req.source_key & KEY_MASK;
    base     = hash_bucket(key, req.sequence_number) * WAYS;
    free_way = -1;
    hit      = 1'b0;
    for (w = 0; w < WAYS; w++) begin
      e = base + w;
      if (slot_live[e] && entry_stale(slot_stamp[e], req.now_ticks)) slot_live[e] = 1'b0;
      if (!slot_live[e]) begin
        if (free_way < 0) free_way = w;
      end else if (slot_seq[e] == req.sequence_number && slot_key[e] == key) begin
        hit = 1'b1;
      end
    end
    if (hit) return DUPLICATE;
    if (free_way < 0) return UNTRACKED;
    e             = base + free_way;
    slot_live[e]  = 1'b1;
    slot_key[e]   = key;
    slot_seq[e]   = req.sequence_number;
    slot_stamp[e] = req.now_ticks;
    return NEW_ENTRY;
  endfunction

  // the multiply is a bijection, so a sequence landing in any bucket can be
  // built backwards from a chosen hash value
  function automatic logic [31:0] seq_into_bucket(input logic [63:0] key,
                                                  input int unsigned bkt);
    logic [31:0] h;
    h = $urandom();
    h[31 -: BKT_BITS] = BKT_BITS'(bkt);
    return (h * golden_inv) ^ key_checksum(key);
  endfunction

  // idle cycles before the next transfer, with quiet stretches of none
  function automatic int idle_draw(inout int quiet);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) quiet = $urandom_range(8, 40);
    return $urandom_range(0, 12);
  endfunction

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------
  task automatic offer_request(input tdf_in_t req, input bit typed, input tdf_out_t typed_res);
    int       gap;
    awaited_t a;
    gap = idle_draw(send_quiet);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    a.req     = req;
    a.verdict = predict_verdict(req);
    if (typed) a.verdict = typed_res;
    awaited_q.push_back(a);
    recent_q.push_back(req);
    if (recent_q.size() > RECENT_DEPTH) void'(recent_q.pop_front());
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (awaited_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_ttl(input logic [31:0] value);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    ttl_model    = value;
  endtask

  // --------------------------------------------------------------------------
  // Directed requests; typed verdicts only where they follow from the rules
  // --------------------------------------------------------------------------
  typedef struct {
    bit          set_ttl;
    logic [31:0] ttl;
    logic [63:0] key;
    logic [31:0] seq;
    logic [31:0] now;
    bit          typed;
    tdf_out_t    verdict;
  } probe_t;

  probe_t probe_table [PROBE_ROWS] = '{
    '{0, 0, 64'h0, 32'h0, 32'd0,    1, NEW_ENTRY},  // empty table
    '{0, 0, 64'h0, 32'h0, 32'd100,  1, DUPLICATE},
    '{0, 0, 64'h0, 32'h0, 32'd1250, 1, DUPLICATE},  // last live tick
    '{0, 0, 64'h0, 32'h0, 32'd1251, 1, NEW_ENTRY},  // expired, stored again
    '{0, 0, '1,    '1,    '1,       1, NEW_ENTRY},
    '{0, 0, '1,    '1,    32'd1249, 1, DUPLICATE},  // stamp + ttl wraps
    '{0, 0, '1,    '1,    32'd1250, 1, NEW_ENTRY},
    '{0, 0, '1,    32'h0, 32'd1250, 0, UNTRACKED},
    '{0, 0, 64'h0, '1,    32'd1250, 0, UNTRACKED},
    '{0, 0, 64'h8000_0000_0000_0000, 32'h8000_0000, 32'h8000_0000, 0, UNTRACKED},
    '{0, 0, 64'hAAAA_AAAA_AAAA_AAAA, 32'h5555_5555, 32'h7FFF_FFFF, 0, UNTRACKED},
    '{0, 0, 64'h5555_5555_5555_5555, 32'hAAAA_AAAA, 32'h8000_0000, 0, UNTRACKED},
    '{0, 0, 64'hAAAA_AAAA_AAAA_AAAA, 32'h5555_5555, 32'h8000_0000, 0, UNTRACKED},
    '{1, 0, 64'h1234, 32'd7, 32'd500, 0, UNTRACKED},  // zero ttl
    '{0, 0, 64'h1234, 32'd7, 32'd500, 0, UNTRACKED},
    '{0, 0, 64'h1234, 32'd7, 32'd501, 0, UNTRACKED}
  };

  initial begin : stimulus
    tdf_in_t     r;
    int          i;
    int          n;
    int          phase;
    int          pick;
    int unsigned bkt;
    int unsigned step_max;
    int unsigned hot [3];
    logic [31:0] now_cur;
    logic [31:0] ttl_plan [PHASES];
    logic [63:0] key_pool [8];

    golden_inv = GOLDEN_32;
    repeat (5) golden_inv = golden_inv * (32'd2 - GOLDEN_32 * golden_inv);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (i = 0; i < PROBE_ROWS; i++) begin
      if (probe_table[i].set_ttl) write_ttl(probe_table[i].ttl);
      r.source_key      = probe_table[i].key;
      r.sequence_number = probe_table[i].seq;
      r.now_ticks       = probe_table[i].now;
      offer_request(r, probe_table[i].typed, probe_table[i].verdict);
    end

    // one bucket pushed past its ways at a single tick
    bkt = $urandom_range(0, BUCKETS - 1);
    now_cur = $urandom();
    repeat (WAYS + 1) begin
      r.source_key      = {$urandom(), $urandom()};
      r.sequence_number = seq_into_bucket(r.source_key, bkt);
      r.now_ticks       = now_cur;
      offer_request(r, 1'b0, UNTRACKED);
    end

    ttl_plan = '{32'd1, '1, 32'h7FFF_FFFF, 32'($urandom_range(50, 20000)), TTL_RESET};

    for (phase = 0; phase < PHASES; phase++) begin
      write_ttl(ttl_plan[phase]);
      step_max = (ttl_plan[phase] <= 32'd3000) ? ttl_plan[phase] / 3 + 1 : 40;
      foreach (key_pool[k]) key_pool[k] = {$urandom(), $urandom()};
      foreach (hot[k]) hot[k] = $urandom_range(0, BUCKETS - 1);
      now_cur = $urandom();
      for (n = 0; n < PHASE_REQUESTS; n++) begin
        // long output stall while requests keep coming
        if (phase == 2 && n == 100) hold_outputs = 1'b1;
        // full pause until every response is back
        if (phase == 3 && n == 150) wait_drained();

        if ($urandom_range(0, 24) == 0) now_cur = $urandom();
        else now_cur = now_cur + $urandom_range(0, step_max);

        pick = $urandom_range(0, 99);
        if (pick < 40 && recent_q.size() > 0) begin
          r = recent_q[$urandom_range(0, recent_q.size() - 1)];
        end else begin
          r.source_key = $urandom_range(0, 1) ? key_pool[$urandom_range(0, 7)]
                                              : {$urandom(), $urandom()};
          if (pick < 65) begin
            r.sequence_number = seq_into_bucket(r.source_key, hot[$urandom_range(0, 2)]);
          end else if ($urandom_range(0, 3) == 0) begin
            r.sequence_number = $urandom_range(0, 15);
          end else begin
            r.sequence_number = $urandom();
          end
        end
        r.now_ticks = now_cur;
        offer_request(r, 1'b0, UNTRACKED);
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && awaited_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Response side: random stalls, one long hold, in-order compare
  // --------------------------------------------------------------------------
  initial begin : response_check
    awaited_t a;
    int       stall;
    @(posedge rst_ni);
    forever begin
      if (hold_outputs) begin
        hold_outputs = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      stall = idle_draw(recv_quiet);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      if (awaited_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: response with nothing owed: dup=%0b tracked=%0b",
                   $time, out_data_o.is_duplicate, out_data_o.was_tracked);
      end else begin
        a = awaited_q.pop_front();
        if (out_data_o.is_duplicate !== a.verdict.is_duplicate ||
            out_data_o.was_tracked !== a.verdict.was_tracked) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: key=%h seq=%h now=%h expected dup=%0b tracked=%0b, got dup=%0b tracked=%0b",
                     $time, a.req.source_key, a.req.sequence_number, a.req.now_ticks,
                     a.verdict.is_duplicate, a.verdict.was_tracked,
                     out_data_o.is_duplicate, out_data_o.was_tracked);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count = cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

endmodule

// ----- files.f -----
+incdir+sv
sv/tdf_pkg.sv
sv/tdf_front.sv
sv/tdf_queue.sv
sv/tdf_back.sv
sv/timed_duplicate_filter.sv
tb/sv/tb_timed_duplicate_filter.sv
